[rtl/core/assert_macros.svh]
// assertion helpers shared by the rtl files
// both sample on clk_i and are off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define LFOFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lfofd check failed");

// condition must never be seen
`define LFOFD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lfofd forbidden condition");

`endif

[rtl/core/lfofd_pkg.sv]
package lfofd_pkg;

  // register file layout
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIX      = 3'd0,
    CFG_FEEDBACK = 3'd1,
    CFG_STEP     = 3'd2,
    CFG_DEPTH    = 3'd3,
    CFG_BASE     = 3'd4,
    CFG_CHANNELS = 3'd5
  } cfg_reg_e;

  localparam int GAIN_W  = 16;
  localparam int STEP_W  = 19;
  localparam int BASE_W  = 13;
  localparam int CH_W    = 2;
  localparam int PHASE_W = 32;
  // base times a factor below two stays below twice the base
  localparam int DLY_W   = BASE_W + 1;

  // q1.15 and q30 fixed point
  localparam int                SINE_W      = 16;
  localparam logic [GAIN_W-1:0] UNITY_Q15   = 16'h8000;
  localparam logic [31:0]       Q30_ONE     = 32'h4000_0000;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

  // operand a of the shared multiplier
  localparam int MUL_A_W = 33;

endpackage

[rtl/core/lfo_modulated_feedback_delay_top.sv]
// channel  dir  handshake                        payload
// in       in   in_valid_i / in_stall_o          left_sample_i, right_sample_i
// out      out  out_valid_o / out_stall_i        out_sample_o
// cfg      in   cfg_we_i (no wait)               cfg_index_i, cfg_data_i
//
// a frame runs addr, dry, wet, fb, write, then done loads the result; a block start
// first runs idx_mul, idx, depth_mul, base_mul, delay and mod, mod repeating per wrap
// reset clears control, pointer, lfo phase, block counter, delay and fill count
// the store reads as zero until written, tracked by a fill count, no clear pass
// in_stall_o is high while a frame is in work or its result cannot be parked
// a result waits in the output register while the next frame is accepted
`include "assert_macros.svh"

module lfo_modulated_feedback_delay_top #(
  parameter int DELAY_DEPTH  = 16384,
  parameter int BLOCK_FRAMES = 16,
  parameter int SINE_ENTRIES = 1024,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [lfofd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lfofd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input frames
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]       right_sample_i,
  // output samples
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       out_sample_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int DCW   = $clog2(DELAY_DEPTH + 1);
  localparam int SIW   = $clog2(SINE_ENTRIES);
  localparam int FIB_W = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
  localparam int MBW   = (SB + 2 > 16) ? SB + 2 : 16;
  localparam int AWID  = lfofd_pkg::MUL_A_W;
  localparam int PW    = AWID + MBW;
  localparam int ACW   = SB + 19;
  localparam int GW    = lfofd_pkg::GAIN_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IDX_MUL,
    S_IDX,
    S_DEPTH_MUL,
    S_BASE_MUL,
    S_DELAY,
    S_MOD,
    S_ADDR,
    S_DRY,
    S_WET,
    S_FB,
    S_WRITE,
    S_DONE
  } state_e;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [GW-1:0]                  mix_q;
  logic [GW-1:0]                  fbg_q;
  logic [lfofd_pkg::STEP_W-1:0]   step_q;
  logic [GW-1:0]                  depth_q;
  logic [lfofd_pkg::BASE_W-1:0]   base_q;
  logic [lfofd_pkg::CH_W-1:0]     ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q   <= '0;
      fbg_q   <= '0;
      step_q  <= '0;
      depth_q <= '0;
      base_q  <= '0;
      ch_q    <= lfofd_pkg::CH_W'(2);
    end else if (cfg_we_i) begin
      unique case (lfofd_pkg::cfg_reg_e'(cfg_index_i))
        lfofd_pkg::CFG_MIX:      mix_q   <= cfg_data_i[GW-1:0];
        lfofd_pkg::CFG_FEEDBACK: fbg_q   <= cfg_data_i[GW-1:0];
        lfofd_pkg::CFG_STEP:     step_q  <= cfg_data_i[lfofd_pkg::STEP_W-1:0];
        lfofd_pkg::CFG_DEPTH:    depth_q <= cfg_data_i[GW-1:0];
        lfofd_pkg::CFG_BASE:     base_q  <= cfg_data_i[lfofd_pkg::BASE_W-1:0];
        lfofd_pkg::CFG_CHANNELS: ch_q    <= cfg_data_i[lfofd_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  // gains above unity act as unity
  function automatic logic [GW-1:0] gain_sat(input logic [GW-1:0] g);
    return (g > lfofd_pkg::UNITY_Q15) ? lfofd_pkg::UNITY_Q15 : g;
  endfunction

  logic [GW-1:0] mix_eff;
  logic [GW-1:0] dry_w;
  logic [GW-1:0] fbg_eff;
  logic [GW-1:0] depth_eff;

  assign mix_eff   = gain_sat(mix_q);
  assign dry_w     = lfofd_pkg::UNITY_Q15 - mix_eff;
  assign fbg_eff   = gain_sat(fbg_q);
  assign depth_eff = gain_sat(depth_q);

  // ---------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------
  state_e                          state_q;
  logic                            out_valid_q;
  logic signed [SB-1:0]            out_sample_q;
  logic [AW-1:0]                   wp_q;
  logic [DCW-1:0]                  fill_q;
  logic [lfofd_pkg::PHASE_W-1:0]   phase_q;
  logic [FIB_W-1:0]                fib_q;
  logic [lfofd_pkg::DLY_W-1:0]     dly_q;

  // datapath, no reset needed
  logic signed [SB:0]              sum_q;
  logic signed [PW-1:0]            prod_q;
  logic signed [ACW-1:0]           acc_q;
  logic signed [SB+1:0]            tap_q;
  logic                            tap_ok_q;
  logic signed [SB-1:0]            res_q;

  logic                            in_acc;
  logic signed [SB:0]              sum_d;
  logic signed [SB:0]              right_term;
  logic [AW-1:0]                   wp_d;
  logic [AW:0]                     rd_sum;
  logic [AW-1:0]                   rd_d;
  logic                            rd_ok;
  logic signed [lfofd_pkg::SINE_W-1:0] sine;
  logic [SB+1:0]                   ram_rdata;
  logic signed [AWID-1:0]          fac;
  logic signed [AWID-1:0]          mul_a;
  logic signed [MBW-1:0]           mul_b;
  logic signed [SB+3:0]            mix_v;
  logic                            mix_ovf;
  logic signed [SB-1:0]            res_d;
  logic signed [SB+2:0]            fbv;
  logic signed [SB+3:0]            fb_diff;
  logic                            fb_ovf;
  logic signed [SB+1:0]            stored;

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;

  // channel count 0 acts as 1, 3 acts as 2
  assign right_term = ch_q[1] ? (SB+1)'(right_sample_i) : (SB+1)'(0);
  assign sum_d      = (SB+1)'(left_sample_i) + right_term;

  assign wp_d = (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + 1'b1;

  // tap address: pointer minus delay, modulo depth
  assign rd_sum = (AW+1)'(wp_q) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(dly_q);
  assign rd_d   = (rd_sum >= (AW+1)'(DELAY_DEPTH)) ?
                  AW'(rd_sum - (AW+1)'(DELAY_DEPTH)) : rd_sum[AW-1:0];
  // entries 1..fill are written, all of them once the store has wrapped
  assign rd_ok  = (fill_q == DCW'(DELAY_DEPTH)) ||
                  ((rd_d != '0) && (DCW'(rd_d) <= fill_q));

  // 1 + depth*sin in q30
  assign fac = $signed(AWID'(lfofd_pkg::Q30_ONE)) + $signed(prod_q[AWID-1:0]);

  // ---------------------------------------------------------------------
  // shared multiplier operand select
  // ---------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_IDX_MUL: begin
        mul_a = $signed(AWID'(phase_q));
        mul_b = $signed(MBW'(SINE_ENTRIES));
      end
      S_DEPTH_MUL: begin
        mul_a = $signed(AWID'(depth_eff));
        mul_b = MBW'(sine);
      end
      S_BASE_MUL: begin
        mul_a = fac;
        mul_b = $signed(MBW'(base_q));
      end
      S_DRY: begin
        mul_a = $signed(AWID'(dry_w));
        mul_b = MBW'(sum_q);
      end
      S_WET: begin
        mul_a = $signed(AWID'(mix_eff));
        mul_b = MBW'(tap_q);
      end
      S_FB: begin
        mul_a = $signed(AWID'(fbg_eff));
        mul_b = MBW'(tap_q);
      end
      default: ;
    endcase
  end

  // mix result, floor shift then saturate
  assign mix_v   = (SB+4)'(acc_q >>> 15);
  assign mix_ovf = !((&mix_v[SB+3:SB-1]) || !(|mix_v[SB+3:SB-1]));
  assign res_d   = mix_ovf ?
                   (mix_v[SB+3] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}}) :
                   mix_v[SB-1:0];

  // feedback write value, saturated to the store width
  assign fbv     = (SB+3)'(prod_q >>> 15);
  assign fb_diff = (SB+4)'(sum_q) - (SB+4)'(fbv);
  assign fb_ovf  = !((&fb_diff[SB+3:SB+1]) || !(|fb_diff[SB+3:SB+1]));
  assign stored  = fb_ovf ?
                   (fb_diff[SB+3] ? {1'b1, {(SB+1){1'b0}}} : {1'b0, {(SB+1){1'b1}}}) :
                   fb_diff[SB+1:0];

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      wp_q         <= '0;
      fill_q       <= '0;
      phase_q      <= '0;
      fib_q        <= '0;
      dly_q        <= '0;
    end else begin
      // the done state loads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            fib_q <= (fib_q == FIB_W'(BLOCK_FRAMES - 1)) ? '0 : fib_q + 1'b1;
            if (fib_q == '0) begin
              phase_q <= phase_q + lfofd_pkg::PHASE_W'(step_q);
              state_q <= S_IDX_MUL;
            end else begin
              state_q <= S_ADDR;
            end
          end
        end
        S_IDX_MUL:   state_q <= S_IDX;
        S_IDX:       state_q <= S_DEPTH_MUL;
        S_DEPTH_MUL: state_q <= S_BASE_MUL;
        S_BASE_MUL:  state_q <= S_DELAY;
        S_DELAY: begin
          dly_q   <= prod_q[30 +: lfofd_pkg::DLY_W];
          state_q <= S_MOD;
        end
        S_MOD: begin
          // wrap the new delay by the store depth, one subtract a cycle
          if (32'(dly_q) >= 32'(DELAY_DEPTH)) begin
            dly_q <= dly_q - lfofd_pkg::DLY_W'(DELAY_DEPTH);
          end else begin
            state_q <= S_ADDR;
          end
        end
        S_ADDR:  state_q <= S_DRY;
        S_DRY:   state_q <= S_WET;
        S_WET:   state_q <= S_FB;
        S_FB:    state_q <= S_WRITE;
        S_WRITE: begin
          wp_q <= wp_d;
          if (fill_q != DCW'(DELAY_DEPTH)) begin
            fill_q <= fill_q + 1'b1;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= res_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      sum_q <= sum_d;
    end
    if (state_q == S_ADDR) begin
      tap_ok_q <= rd_ok;
    end
    if (state_q == S_DRY) begin
      tap_q <= tap_ok_q ? $signed(ram_rdata) : '0;
    end
    if (state_q == S_WET) begin
      acc_q <= ACW'(prod_q);
    end
    if (state_q == S_FB) begin
      acc_q <= acc_q + ACW'(prod_q);
    end
    if (state_q == S_WRITE) begin
      res_q <= res_d;
    end
  end

  // ---------------------------------------------------------------------
  // sine table and delay store
  // ---------------------------------------------------------------------
  lfofd_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .idx_i  (prod_q[32 +: SIW]),
    .sine_o (sine)
  );

  lfofd_ram #(
    .WIDTH (SB + 2),
    .DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WRITE),
    .waddr_i (wp_d),
    .wdata_i (stored),
    .raddr_i (rd_d),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `LFOFD_ASSERT(a_delay_wrapped, (state_q == S_ADDR) |-> (int'(dly_q) < DELAY_DEPTH))
  `LFOFD_ASSERT_NEVER(a_fill_bound, int'(fill_q) > DELAY_DEPTH)
  `LFOFD_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE))
  `LFOFD_ASSERT(a_block_start, (in_acc && (fib_q == '0)) |=> (state_q == S_IDX_MUL))

endmodule

[rtl/core/lfofd_ram.sv]
module lfofd_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lfofd_sine_rom.sv]
module lfofd_sine_rom #(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                            clk_i,
  input  logic [$clog2(SINE_ENTRIES)-1:0] idx_i,
  output logic signed [lfofd_pkg::SINE_W-1:0] sine_o
);

  typedef logic signed [lfofd_pkg::SINE_W-1:0] rom_t [SINE_ENTRIES];

  // quarter-wave fold, then 11th order taylor series in q30
  function automatic logic signed [lfofd_pkg::SINE_W-1:0] sine_val(input int unsigned i);
    logic [63:0] num;
    logic [31:0] f;
    logic [1:0]  q;
    logic [63:0] r;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] one;
    num = 64'(i) << 32;
    f   = 32'(num / SINE_ENTRIES);
    q   = f[31:30];
    r   = {34'd0, f[29:0]};
    one = 64'(lfofd_pkg::Q30_ONE);
    if (q[0]) begin
      r = one - r;
    end
    th  = (r * lfofd_pkg::HALF_PI_Q30) >> 30;
    th2 = (th * th) >> 30;
    acc = one;
    acc = one - ((th2 * acc) >> 30) / 110;
    acc = one - ((th2 * acc) >> 30) / 72;
    acc = one - ((th2 * acc) >> 30) / 42;
    acc = one - ((th2 * acc) >> 30) / 20;
    acc = one - ((th2 * acc) >> 30) / 6;
    s = (th * acc) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    if (q[1]) begin
      return -$signed(lfofd_pkg::SINE_W'(s));
    end
    return $signed(lfofd_pkg::SINE_W'(s));
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int unsigned i = 0; i < SINE_ENTRIES; i++) begin
      t[i] = sine_val(i);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic signed [lfofd_pkg::SINE_W-1:0] sine_q;

  always_ff @(posedge clk_i) begin
    sine_q <= SINE_ROM[idx_i];
  end

  assign sine_o = sine_q;

endmodule

[dv/lfo_modulated_feedback_delay_top_test.sv]
`timescale 1ns / 100ps

module lfo_modulated_feedback_delay_top_test;

  // settings for one phase, written to every register before the phase starts
  typedef struct {
    logic [15:0] mix;
    logic [15:0] feedback;
    logic [18:0] step;
    logic [15:0] depth;
    logic [12:0] base;
    logic [1:0]  channels;
  } flanger_settings_t;

  // tracks the flanger state and holds the samples the block still owes us
  class flanger_scoreboard;
    int                 sine_q15 [1024];
    int                 delay_line [16384];
    bit [13:0]          wr_ptr;
    bit [31:0]          lfo_phase;
    bit [3:0]           block_pos;
    bit [13:0]          tap_delay;
    bit [15:0]          mix_level;
    bit [15:0]          feedback_gain;
    bit [18:0]          phase_step;
    bit [15:0]          depth_gain;
    bit [12:0]          base_delay;
    bit [1:0]           channels_used;
    logic signed [15:0] expected_samples [$];
    int                 mismatches;
    int                 frames_seen;
    int                 samples_checked;
    int                 saturated;
    int                 longest_delay;

    function new();
      longint unsigned f, r, th, th2, acc, s;
      longint unsigned taylor_div [5];
      int              quad;
      taylor_div = '{110, 72, 42, 20, 6};
      // quarter-wave fold, then an odd taylor series in q30
      for (int i = 0; i < 1024; i++) begin
        f    = longint'(i) << 22;
        quad = i >> 8;
        r    = f & 64'h3FFF_FFFF;
        if ((quad & 1) != 0) begin
          r = (64'd1 << 30) - r;
        end
        th  = (r * lfofd_pkg::HALF_PI_Q30) >> 30;
        th2 = (th * th) >> 30;
        acc = 64'd1 << 30;
        for (int k = 0; k < 5; k++) begin
          acc = (64'd1 << 30) - ((th2 * acc) >> 30) / taylor_div[k];
        end
        s = (th * acc) >> 30;
        s = (s + (64'd1 << 14)) >> 15;
        if (s > 32767) begin
          s = 32767;
        end
        sine_q15[i] = (quad >= 2) ? -int'(s) : int'(s);
      end
      foreach (delay_line[i]) delay_line[i] = 0;
      wr_ptr        = '0;
      lfo_phase     = '0;
      block_pos     = '0;
      tap_delay     = '0;
      mix_level     = '0;
      feedback_gain = '0;
      phase_step    = '0;
      depth_gain    = '0;
      base_delay    = '0;
      channels_used = 2'd2;
    endfunction

    function longint unity_cap(bit [15:0] g);
      return (g > 16'd32768) ? 64'sd32768 : longint'(g);
    endfunction

    function longint clamp_bits(longint v, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void write_reg(lfofd_pkg::cfg_reg_e idx, logic [18:0] v);
      case (idx)
        lfofd_pkg::CFG_MIX:      mix_level     = v[15:0];
        lfofd_pkg::CFG_FEEDBACK: feedback_gain = v[15:0];
        lfofd_pkg::CFG_STEP:     phase_step    = v[18:0];
        lfofd_pkg::CFG_DEPTH:    depth_gain    = v[15:0];
        lfofd_pkg::CFG_BASE:     base_delay    = v[12:0];
        lfofd_pkg::CFG_CHANNELS: channels_used = v[1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    // one accepted frame: advance the lfo on a block start, read the tap,
    // mix, then write the feedback value one slot ahead
    function void note_frame(logic signed [15:0] l, logic signed [15:0] r);
      longint    sum, tap, mix, wet, fbv, stored, m, d;
      bit [13:0] rd;
      bit [9:0]  idx;
      sum = longint'(l);
      if (channels_used >= 2) begin
        sum = sum + longint'(r);
      end
      if (block_pos == 0) begin
        lfo_phase = lfo_phase + phase_step;
        idx       = lfo_phase[31:22];
        m         = unity_cap(depth_gain) * sine_q15[idx];
        d         = (longint'(base_delay) * ((longint'(1) << 30) + m)) >>> 30;
        tap_delay = 14'(d % 16384);
        if (tap_delay > longest_delay) begin
          longest_delay = tap_delay;
        end
      end
      block_pos = block_pos + 1'b1;
      rd  = wr_ptr - tap_delay;
      tap = longint'(delay_line[rd]);
      mix = unity_cap(mix_level);
      wet = ((64'sd32768 - mix) * sum + mix * tap) >>> 15;
      if (clamp_bits(wet, 16) != wet) begin
        saturated++;
      end
      fbv    = (unity_cap(feedback_gain) * tap) >>> 15;
      stored = clamp_bits(sum - fbv, 18);
      wr_ptr = wr_ptr + 1'b1;
      delay_line[wr_ptr] = int'(stored);
      expected_samples.push_back(16'(clamp_bits(wet, 16)));
      frames_seen++;
    endfunction

    function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (expected_samples.size() == 0) begin
        $display("%0t: out_sample %0d with no frame pending", $time, got);
        mismatches++;
        return;
      end
      want = expected_samples.pop_front();
      samples_checked++;
      if (got !== want) begin
        $display("%0t: out_sample mismatch, expected %0d, got %0d", $time, want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  lfofd_pkg::cfg_reg_e  cfg_index;
  logic [18:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [15:0]   left_sample;
  logic signed [15:0]   right_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [15:0]   out_sample;

  // idling knobs, percent per cycle
  int                 gap_pct;
  int                 stall_pct;
  // long receiver hold-off, raised at a rising edge, taken at the next falling edge
  bit                 hold_req;
  int                 hold_left;
  int                 phases_run;

  flanger_scoreboard  sb;

  lfo_modulated_feedback_delay_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .left_sample_i  (left_sample),
    .right_sample_i (right_sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_sample_o   (out_sample)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog, far beyond the slowest legal run
  initial begin
    #400_000;
    $display("lfo_modulated_feedback_delay_top test failed");
    $finish;
  end

  // beat monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_frame(left_sample, right_sample);
      end
      if (out_valid && !out_stall) begin
        sb.check_sample(out_sample);
      end
    end
  end

  // receiver: random stalls, or a counted long hold-off when asked
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // offer one frame, keep it steady until the block takes it
  task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    left_sample  <= l;
    right_sample <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input lfofd_pkg::cfg_reg_e idx, input logic [18:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  // only called with the block idle
  task automatic apply_settings(input flanger_settings_t s);
    write_reg(lfofd_pkg::CFG_MIX,      19'(s.mix));
    write_reg(lfofd_pkg::CFG_FEEDBACK, 19'(s.feedback));
    write_reg(lfofd_pkg::CFG_STEP,     s.step);
    write_reg(lfofd_pkg::CFG_DEPTH,    19'(s.depth));
    write_reg(lfofd_pkg::CFG_BASE,     19'(s.base));
    write_reg(lfofd_pkg::CFG_CHANNELS, 19'(s.channels));
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  // knobs change half a cycle away from the receiver's falling-edge decision
  task automatic set_idling(input int gap, input int stall, input bit long_hold);
    @(posedge clk);
    gap_pct   = gap;
    stall_pct = stall;
    if (long_hold) begin
      hold_req = 1'b1;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // gains include unity and the above-unity codes that must clip to one
  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 6))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic flanger_settings_t random_settings();
    flanger_settings_t s;
    s.mix      = pick_gain();
    s.feedback = pick_gain();
    s.depth    = pick_gain();
    case ($urandom_range(0, 3))
      0:       s.step = 19'd0;
      1:       s.step = 19'h7FFFF;
      default: s.step = 19'($urandom);
    endcase
    // short delays mostly, so the tap lands on frames written in this run
    case ($urandom_range(0, 7))
      0:       s.base = 13'd0;
      1:       s.base = 13'h1FFF;
      2:       s.base = 13'd4410;
      3:       s.base = 13'($urandom);
      default: s.base = 13'($urandom_range(1, 400));
    endcase
    s.channels = 2'($urandom_range(0, 3));
    return s;
  endfunction

  initial begin
    flanger_settings_t s;
    int                n;
    sb           = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = lfofd_pkg::CFG_MIX;
    cfg_data     = '0;
    in_valid     = 1'b0;
    left_sample  = '0;
    right_sample = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    phases_run   = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: full wet, one-sample delay, both channels at their extremes
    s = '{mix: 16'd32768, feedback: 16'd0, step: 19'd0, depth: 16'd0,
          base: 13'd1, channels: 2'd2};
    apply_settings(s);
    send_frame(16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh0000, 16'shFFFF);
    send_frame(16'shFFFF, 16'shFFFF);
    wait_drained();

    // dry only with saturation, zero delay, gains above one, channel code three
    s = '{mix: 16'd0, feedback: 16'hFFFF, step: 19'h7FFFF, depth: 16'hFFFF,
          base: 13'd0, channels: 2'd3};
    apply_settings(s);
    send_frame(16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh8000, 16'sh7FFF);
    send_frame(16'sh5555, 16'shAAAA);
    send_frame(16'shAAAA, 16'sh5555);
    wait_drained();

    // mix above one, channel code zero, full feedback; lands mid-block
    s = '{mix: 16'hFFFF, feedback: 16'd32768, step: 19'd0, depth: 16'd32768,
          base: 13'd2, channels: 2'd0};
    apply_settings(s);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh8000, 16'sh7FFF);
    send_frame(16'sh7FFF, 16'sh0000);
    send_frame(16'sh8000, 16'sh0000);
    send_frame(16'sh1234, 16'shFFFF);
    wait_drained();

    // longest base delay, left only, fastest lfo
    s = '{mix: 16'd16384, feedback: 16'd16384, step: 19'h7FFFF, depth: 16'd32768,
          base: 13'h1FFF, channels: 2'd1};
    apply_settings(s);
    for (int i = 0; i < 5; i++) begin
      send_frame(pick_sample(), pick_sample());
    end
    wait_drained();

    // random phases cycle through the four idling modes
    for (int p = 0; p < 14; p++) begin
      apply_settings(random_settings());
      case (p % 4)
        0: set_idling(0, 0, p == 4);
        1: set_idling(68, 0, 1'b0);
        2: set_idling(0, 68, p == 2);
        3: set_idling(26, 26, 1'b0);
      endcase
      n = $urandom_range(35, 65);
      for (int i = 0; i < n; i++) begin
        // sender holds back once until every owed sample is out
        if (p == 5 && i == n / 2) begin
          wait_drained();
        end
        send_frame(pick_sample(), pick_sample());
      end
      wait_drained();
    end

    // quiet tail, any stray beat is caught by the monitor
    set_idling(0, 0, 1'b0);
    repeat (20) @(negedge clk);

    $display("ran %0d frames through %0d register settings, %0d samples checked",
             sb.frames_seen, phases_run, sb.samples_checked);
    $display("saw %0d saturated outputs and delays up to %0d samples",
             sb.saturated, sb.longest_delay);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("lfo_modulated_feedback_delay_top test passed");
    end else begin
      $display("lfo_modulated_feedback_delay_top test failed");
    end
    $finish;
  end

endmodule
